@@ sv/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Request and result beat layouts, request and target codes, register offsets.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Bank number widths of the built ROMs
  localparam int PRG_BANK_BITS = 5;
  localparam int CHR_BANK_BITS = 8;

  // Field widths
  localparam int REQ_TYPE_W = 2;
  localparam int CPU_ADDR_W = 16;
  localparam int DATA_W     = 8;
  localparam int PPU_ADDR_W = 14;
  localparam int TARGET_W   = 3;
  localparam int MAP_ADDR_W = 19;

  // Stored bank widths
  localparam int CHR_REG_W  = 16;
  localparam int PRG_REG_W  = 8;
  localparam int MIRROR_W   = 2;
  localparam int CHR_BANKS  = 8;
  localparam int CHR_IDX_W  = $clog2(CHR_BANKS);

  // Window offsets within a bank
  localparam int PRG_PAGE_W = 14;
  localparam int CHR_PAGE_W = 10;
  localparam int RAM_PAGE_W = 13;

  // Register offset field: (addr & 0xFFF) >> 2
  localparam int REG_IDX_W  = 10;

  // Request types
  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CPU   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_PPU   = 2'd2;

  // Result targets
  localparam logic [TARGET_W-1:0] TGT_NONE    = 3'd0;
  localparam logic [TARGET_W-1:0] TGT_PRG_RAM = 3'd1;
  localparam logic [TARGET_W-1:0] TGT_PRG_ROM = 3'd2;
  localparam logic [TARGET_W-1:0] TGT_CHR_ROM = 3'd3;
  localparam logic [TARGET_W-1:0] TGT_NT_RAM  = 3'd4;

  // Register offsets
  localparam logic [REG_IDX_W-1:0] REG_CHR_LO_L = 10'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHR_HI_L = 10'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHR_LO_H = 10'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHR_HI_H = 10'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRG      = 10'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIRROR   = 10'd5;

  // Mirroring modes
  localparam logic [MIRROR_W-1:0] MIR_VERT   = 2'd0;
  localparam logic [MIRROR_W-1:0] MIR_HORZ   = 2'd1;
  localparam logic [MIRROR_W-1:0] MIR_SINGLE = 2'd2;

  // Fixed bank at $C000, masked to the PRG size
  localparam logic [PRG_BANK_BITS-1:0] PRG_FIXED_BANK = '1;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [CPU_ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0]     write_data;
    logic [PPU_ADDR_W-1:0] ppu_address;
  } req_t;

  typedef struct packed {
    logic [TARGET_W-1:0]   target;
    logic [MAP_ADDR_W-1:0] mapped_address;
  } rsp_t;

endpackage

@@ sv/cbm_req_if.sv @@
// ----------------------------------------------------------------------------
// cbm_req_if: request channel
// Valid/ready channel carrying one mapper request per beat.
// ----------------------------------------------------------------------------
interface cbm_req_if;
  import cbm_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/cbm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cbm_rsp_if: result channel
// Valid/ready channel carrying one translated address per beat.
// ----------------------------------------------------------------------------
interface cbm_rsp_if;
  import cbm_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/cartridge_bank_mapper.sv @@
// An accepted request beat passes through the stage 1 register and then the
// result register. Throughput: one beat per cycle while out_ch.ready allows;
// stage 1 hands off whenever the result register is empty or being drained.
// Reset (synchronous, rst_n low): all CHR and PRG banks clear to zero,
// mirroring goes to single screen, both pipeline registers empty.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: bank-switching cartridge mapper
// Decodes register writes at $C000-$FFFF and translates CPU and PPU bus
// addresses into PRG RAM, PRG ROM, CHR ROM or nametable addresses.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  logic       clk,
  input  logic       rst_n,
  cbm_req_if.sink    in_ch,
  cbm_rsp_if.source  out_ch
);
  import cbm_pkg::*;

  // Pipeline registers
  logic                  s1_valid_r;
  req_t                  s1_data_r;
  logic                  out_valid_r;
  rsp_t                  out_data_r;
  rsp_t                  out_data_nxt;

  // Mapper state
  logic [CHR_REG_W-1:0]  chr_bank_r   [CHR_BANKS];
  logic [CHR_REG_W-1:0]  chr_bank_nxt [CHR_BANKS];
  logic [PRG_REG_W-1:0]  prg_bank_r;
  logic [PRG_REG_W-1:0]  prg_bank_nxt;
  logic [MIRROR_W-1:0]   mirror_r;
  logic [MIRROR_W-1:0]   mirror_nxt;

  logic                  out_free;
  logic                  s1_adv;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [1:0]            slot;
  logic [31:0]           prg_wide;
  logic [31:0]           chr_wide;
  logic [PRG_BANK_BITS-1:0] prg_sel;
  logic [CHR_REG_W-1:0]  chr_sel;
  logic                  nt_page;

  // Handshake: stage 1 moves on when the result register can take a beat
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign reg_idx = s1_data_r.cpu_address[REG_IDX_W+1:2];
  assign slot    = s1_data_r.cpu_address[1:0];

  // Decode register writes
  always_comb begin
    chr_bank_nxt = chr_bank_r;
    prg_bank_nxt = prg_bank_r;
    mirror_nxt   = mirror_r;
    if (s1_data_r.req_type == REQ_WRITE && s1_data_r.cpu_address[15:14] == 2'b11) begin
      unique case (reg_idx)
        REG_CHR_LO_L: chr_bank_nxt[{1'b0, slot}][7:0]  = s1_data_r.write_data;
        REG_CHR_HI_L: chr_bank_nxt[{1'b0, slot}][15:8] = s1_data_r.write_data;
        REG_CHR_LO_H: chr_bank_nxt[{1'b1, slot}][7:0]  = s1_data_r.write_data;
        REG_CHR_HI_H: chr_bank_nxt[{1'b1, slot}][15:8] = s1_data_r.write_data;
        REG_PRG:      prg_bank_nxt = s1_data_r.write_data;
        REG_MIRROR:   mirror_nxt   = {1'b0, s1_data_r.write_data[0]};
        default: begin
        end
      endcase
    end
  end

  // Translate the request held in stage 1
  always_comb begin
    if (s1_data_r.cpu_address[15:14] == 2'b11) begin
      prg_sel = PRG_FIXED_BANK;
    end else begin
      prg_sel = prg_bank_r[PRG_BANK_BITS-1:0];
    end
    prg_wide = (32'(prg_sel) << PRG_PAGE_W)
             | 32'(s1_data_r.cpu_address[PRG_PAGE_W-1:0]);

    chr_sel  = chr_bank_r[s1_data_r.ppu_address[CHR_PAGE_W+CHR_IDX_W-1:CHR_PAGE_W]];
    chr_wide = (32'(chr_sel[CHR_BANK_BITS-1:0]) << CHR_PAGE_W)
             | 32'(s1_data_r.ppu_address[CHR_PAGE_W-1:0]);

    case (mirror_r)
      MIR_VERT: nt_page = s1_data_r.ppu_address[10];
      MIR_HORZ: nt_page = s1_data_r.ppu_address[11];
      default:  nt_page = 1'b0;
    endcase

    out_data_nxt.target         = TGT_NONE;
    out_data_nxt.mapped_address = '0;
    case (s1_data_r.req_type)
      REQ_CPU: begin
        if (s1_data_r.cpu_address[15]) begin
          out_data_nxt.target         = TGT_PRG_ROM;
          out_data_nxt.mapped_address = prg_wide[MAP_ADDR_W-1:0];
        end else if (s1_data_r.cpu_address[15:13] == 3'b011) begin
          out_data_nxt.target         = TGT_PRG_RAM;
          out_data_nxt.mapped_address =
            MAP_ADDR_W'(s1_data_r.cpu_address[RAM_PAGE_W-1:0]);
        end
      end
      REQ_PPU: begin
        if (!s1_data_r.ppu_address[13]) begin
          out_data_nxt.target         = TGT_CHR_ROM;
          out_data_nxt.mapped_address = chr_wide[MAP_ADDR_W-1:0];
        end else begin
          out_data_nxt.target         = TGT_NT_RAM;
          out_data_nxt.mapped_address =
            MAP_ADDR_W'({nt_page, s1_data_r.ppu_address[CHR_PAGE_W-1:0]});
        end
      end
      default: begin
      end
    endcase
  end

  // Control and mapper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHR_BANKS; i++) begin
        chr_bank_r[i] <= '0;
      end
      prg_bank_r  <= '0;
      mirror_r    <= MIR_SINGLE;
    end else begin
      // take a new beat whenever stage 1 is empty or draining
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      // load the result register, or drop it once drained
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      // commit register writes as the beat leaves stage 1
      if (s1_adv) begin
        chr_bank_r <= chr_bank_nxt;
        prg_bank_r <= prg_bank_nxt;
        mirror_r   <= mirror_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 beat did not reach the result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_mirror_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mirror_r != 2'd3)
    else $error("mirroring mode holds an unused code");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.target == TGT_NONE |-> out_data_r.mapped_address == '0)
    else $error("result with no target carries an address");

endmodule

@@ test/tb_cartridge_bank_mapper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper: self-checking bench for the bank-switching mapper
// Sends register writes and CPU/PPU translate beats over the request channel.
// A local copy of the bank registers predicts each target and mapped address.
// A checker compares every result beat, in order, against that prediction.
// Both channels idle at random, and one long output hold-off stalls the input.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper;
  import cbm_pkg::*;

  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 4;
  localparam int          HOLD_CYCLES   = 64;
  localparam int          BURST_ITEMS   = 24;
  localparam int          RANDOM_ITEMS  = 1600;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int          MAX_REPORTS   = 20;

  // Request type with no function in the block
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [31:0] PRG_MASK   = (32'd1 << PRG_BANK_BITS) - 32'd1;
  localparam logic [31:0] CHR_MASK   = (32'd1 << CHR_BANK_BITS) - 32'd1;
  localparam logic [31:0] FIXED_BANK = 32'h0000_00FF;

  logic clk;
  logic rst_n;

  cbm_req_if in_ch ();
  cbm_rsp_if out_ch ();

  cartridge_bank_mapper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the mapper registers
  logic [CHR_REG_W-1:0] chr_bank_q [CHR_BANKS];
  logic [PRG_REG_W-1:0] prg_bank_q;
  logic [MIRROR_W-1:0]  mirror_q;

  rsp_t        expected_maps [$];
  rsp_t        want_beat;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned n_writes, n_cpu, n_ppu, n_unused;
  bit          hold_off_req;
  int          stall_left;
  int          ready_quiet;
  int          sender_quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Count one mismatch and print it while the log is still short
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
               results_checked, what, got, want);
    error_count++;
  endtask

  function automatic void clear_mapper_state();
    for (int i = 0; i < CHR_BANKS; i++) chr_bank_q[i] = '0;
    prg_bank_q = '0;
    mirror_q   = MIR_SINGLE;
  endfunction

  // Apply one request to the local registers and return the expected result
  function automatic rsp_t map_request(input req_t r);
    rsp_t                 res;
    logic [REG_IDX_W-1:0] idx;
    logic [2:0]           lo_slot;
    logic [2:0]           hi_slot;
    logic [PPU_ADDR_W-1:0] pa;
    logic                 page;
    logic [31:0]          addr;

    res     = '0;
    res.target = TGT_NONE;
    idx     = REG_IDX_W'((r.cpu_address & 16'h0FFF) >> 2);
    lo_slot = {1'b0, r.cpu_address[1:0]};
    hi_slot = {1'b1, r.cpu_address[1:0]};
    pa      = r.ppu_address;
    addr    = '0;
    case (r.req_type)
      REQ_WRITE: begin
        if (r.cpu_address >= 16'hC000) begin
          case (idx)
            REG_CHR_LO_L: chr_bank_q[lo_slot] = (chr_bank_q[lo_slot] & 16'hFF00)
                                                | 16'(r.write_data);
            REG_CHR_HI_L: chr_bank_q[lo_slot] = (chr_bank_q[lo_slot] & 16'h00FF)
                                                | {r.write_data, 8'h00};
            REG_CHR_LO_H: chr_bank_q[hi_slot] = (chr_bank_q[hi_slot] & 16'hFF00)
                                                | 16'(r.write_data);
            REG_CHR_HI_H: chr_bank_q[hi_slot] = (chr_bank_q[hi_slot] & 16'h00FF)
                                                | {r.write_data, 8'h00};
            REG_PRG:      prg_bank_q = r.write_data;
            REG_MIRROR:   mirror_q   = {1'b0, r.write_data[0]};
            default: ;
          endcase
        end
      end
      REQ_CPU: begin
        if (r.cpu_address >= 16'hC000) begin
          res.target = TGT_PRG_ROM;
          addr = ((FIXED_BANK & PRG_MASK) << 14) | 32'(r.cpu_address & 16'h3FFF);
        end else if (r.cpu_address >= 16'h8000) begin
          res.target = TGT_PRG_ROM;
          addr = ((32'(prg_bank_q) & PRG_MASK) << 14) | 32'(r.cpu_address & 16'h3FFF);
        end else if (r.cpu_address >= 16'h6000) begin
          res.target = TGT_PRG_RAM;
          addr = 32'(r.cpu_address & 16'h1FFF);
        end
      end
      REQ_PPU: begin
        if (pa < 14'h2000) begin
          res.target = TGT_CHR_ROM;
          addr = ((32'(chr_bank_q[pa[12:10]]) & CHR_MASK) << 10) | 32'(pa[9:0]);
        end else begin
          case (mirror_q)
            MIR_VERT: page = pa[10];
            MIR_HORZ: page = pa[11];
            default:  page = 1'b0;
          endcase
          res.target = TGT_NT_RAM;
          addr = {21'd0, page, pa[9:0]};
        end
      end
      default: ;
    endcase
    res.mapped_address = addr[MAP_ADDR_W-1:0];
    return res;
  endfunction

  function automatic req_t make_req(input logic [REQ_TYPE_W-1:0] kind,
                                    input logic [CPU_ADDR_W-1:0] caddr,
                                    input logic [DATA_W-1:0] wdata,
                                    input logic [PPU_ADDR_W-1:0] paddr);
    req_t r;
    r.req_type    = kind;
    r.cpu_address = caddr;
    r.write_data  = wdata;
    r.ppu_address = paddr;
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, and quiet runs
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (sender_quiet > 0) begin
      sender_quiet--;
      return 0;
    end
    if (p < 2) begin
      sender_quiet = $urandom_range(40, 100);
      return 0;
    end
    if (p < 75) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offer one request beat, hold it until accepted, record its prediction
  task automatic send_beat(input req_t r, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    expected_maps.push_back(map_request(r));
    case (r.req_type)
      REQ_WRITE: n_writes++;
      REQ_CPU:   n_cpu++;
      REQ_PPU:   n_ppu++;
      default:   n_unused++;
    endcase
  endtask

  // Receiver: random stalls, quiet runs, and the long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    ready_quiet  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (ready_quiet > 0) begin
        out_ch.ready <= 1'b1;
        ready_quiet--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  out_ch.ready <= 1'b1;
          [70:94]: begin
            stall_left = $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
          end
          [95:97]: begin
            stall_left = $urandom_range(8, 24);
            out_ch.ready <= 1'b0;
          end
          default: begin
            ready_quiet = $urandom_range(50, 150);
            out_ch.ready <= 1'b1;
          end
        endcase
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("unexpected result beat, target", 32'(out_ch.data.target),
                        32'(TGT_NONE));
      end else begin
        want_beat = expected_maps.pop_front();
        if (out_ch.data.target !== want_beat.target)
          report_mismatch("target", 32'(out_ch.data.target), 32'(want_beat.target));
        if (out_ch.data.mapped_address !== want_beat.mapped_address)
          report_mismatch("mapped_address", 32'(out_ch.data.mapped_address),
                          32'(want_beat.mapped_address));
      end
      results_checked++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_maps.size());
      $display("tb_cartridge_bank_mapper failed");
      $finish;
    end
  end

  // Translations straight after reset: bank 0 in the switchable windows, the fixed bank at $C000, single-screen page
  task automatic test_power_on_map();
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h3FFF), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_CPU, 16'h0000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_CPU, 16'h5FFF, 8'hFF, 14'h3FFF), pick_gap());
    send_beat(make_req(REQ_CPU, 16'h6000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_CPU, 16'h7FFF, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_CPU, 16'h8000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_CPU, 16'hFFFF, 8'h00, 14'h0000), pick_gap());
  endtask

  // Every register offset, low and high CHR halves, mirror alias at $D000
  task automatic test_bank_writes();
    send_beat(make_req(REQ_WRITE, 16'hC000, 8'hFF, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hC007, 8'hFF, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hC00B, 8'h80, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hC00E, 8'h01, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hC010, 8'hFF, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hD015, 8'h01, 14'h0000), pick_gap());
  endtask

  // Writes below $C000, offsets above the mirror register, unused type
  task automatic test_ignored_writes();
    send_beat(make_req(REQ_WRITE, 16'hB014, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_WRITE, 16'hC018, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_UNUSED, 16'hC010, 8'h00, 14'h3FFF), pick_gap());
  endtask

  // Translations through the written banks and both mirroring modes
  task automatic test_banked_map();
    send_beat(make_req(REQ_CPU, 16'h8000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h0000), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h0FFF), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h1FFF), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h2C00), pick_gap());
    // Only bit 0 selects the mode: 0xFE gives vertical
    send_beat(make_req(REQ_WRITE, 16'hC014, 8'hFE, 14'h0000), pick_gap());
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h2400), pick_gap());
    // Palette range still maps as nametable space
    send_beat(make_req(REQ_PPU, 16'h0000, 8'h00, 14'h3F00), pick_gap());
  endtask

  // Hold the output off while the sender keeps offering beats
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_beat(make_req(REQ_TYPE_W'($urandom_range(0, 2)), CPU_ADDR_W'($urandom),
                         DATA_W'($urandom), PPU_ADDR_W'($urandom)), 0);
    end
  endtask

  function automatic req_t random_request();
    req_t r;
    int   p;
    r.cpu_address = CPU_ADDR_W'($urandom);
    r.write_data  = DATA_W'($urandom);
    r.ppu_address = PPU_ADDR_W'($urandom);
    p = $urandom_range(0, 99);
    if (p < 30) begin
      r.req_type = REQ_WRITE;
      // Most writes hit a real register, the rest land anywhere
      if ($urandom_range(0, 4) != 0)
        r.cpu_address = 16'hC000 | (16'($urandom_range(0, 3)) << 12)
                        | (16'($urandom_range(0, 5)) << 2) | 16'($urandom_range(0, 3));
    end else if (p < 62) begin
      r.req_type = REQ_CPU;
    end else if (p < 96) begin
      r.req_type = REQ_PPU;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_beat(random_request(), pick_gap());
    end
  endtask

  // Stimulus sequence
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    hold_off_req = 1'b0;
    sender_quiet = 0;
    error_count  = 0;
    results_checked = 0;
    cycle_count  = 0;
    n_writes = 0;
    n_cpu    = 0;
    n_ppu    = 0;
    n_unused = 0;
    clear_mapper_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_power_on_map();
    test_bank_writes();
    test_ignored_writes();
    test_banked_map();
    test_output_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d register writes, %0d CPU and %0d PPU translations, %0d unused beats",
             n_writes, n_cpu, n_ppu, n_unused);
    $display("checked %0d result beats with random stalls and a %0d-cycle output hold-off",
             results_checked, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("tb_cartridge_bank_mapper passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_cartridge_bank_mapper failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cbm_pkg.sv
sv/cbm_req_if.sv
sv/cbm_rsp_if.sv
sv/cartridge_bank_mapper.sv
test/tb_cartridge_bank_mapper.sv
